// ===== sv/ufr_pkg.sv =====
// Shared types, codes and reset values for the update frame receiver.
package ufr_pkg;

  localparam int ByteW  = 8;
  localparam int AddrW  = 16;
  localparam int CountW = 16;
  localparam int PosW   = 9;
  localparam int EventW = 3;
  localparam int CfgIdxW = 2;

  // Event codes
  localparam logic [EventW-1:0] EV_ABSORB = 3'd0;
  localparam logic [EventW-1:0] EV_START  = 3'd1;
  localparam logic [EventW-1:0] EV_END    = 3'd2;
  localparam logic [EventW-1:0] EV_ACCEPT = 3'd3;
  localparam logic [EventW-1:0] EV_REJECT = 3'd4;
  localparam logic [EventW-1:0] EV_DROP   = 3'd5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_START_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END_CODE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ACK_CODE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_NACK_CODE  = 2'd3;

  // Register reset values
  localparam logic [ByteW-1:0] START_CODE_RST = 8'h0F;
  localparam logic [ByteW-1:0] END_CODE_RST   = 8'hF0;
  localparam logic [ByteW-1:0] ACK_CODE_RST   = 8'h79;
  localparam logic [ByteW-1:0] NACK_CODE_RST  = 8'h7F;

  // Header bytes ahead of the data: length, offset high, offset low
  localparam logic [PosW-1:0] HDR_LEN = 9'd3;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] ack_code;
    logic [ByteW-1:0] nack_code;
  } codes_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ByteW-1:0]  reply_byte;
    logic              payload_valid;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  payload_offset;
    logic [ByteW-1:0]  frame_length;
    logic [AddrW-1:0]  flash_offset;
    logic [AddrW-1:0]  record_address;
    logic [ByteW-1:0]  record_check;
    logic [CountW-1:0] frames_stored;
    logic              program_ready;
  } result_t;

endpackage

// ===== sv/update_frame_receiver_unit.sv =====
// Top level of the update frame receiver: input register, parser core, result register.
// Takes one received byte per beat and returns exactly one result beat for it. A byte
// passes an input register, then the parser state and the result register are updated
// together in the same cycle, so a new byte is taken every cycle unless the output side
// stalls. Its result then sits in the result register and can be taken when the output
// side is not stalled. The single parser state
// update per cycle sets this rate. Code registers are written through the cfg_ port,
// which is always ready; write them only while no byte is in flight.
module update_frame_receiver_unit
  import ufr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [EventW-1:0]  out_event_res,
  output logic [ByteW-1:0]   out_reply_byte,
  output logic               out_payload_valid,
  output logic [ByteW-1:0]   out_payload_byte,
  output logic [ByteW-1:0]   out_payload_offset,
  output logic [ByteW-1:0]   out_frame_length,
  output logic [AddrW-1:0]   out_flash_offset,
  output logic [AddrW-1:0]   out_record_address,
  output logic [ByteW-1:0]   out_record_check,
  output logic [CountW-1:0]  out_frames_stored,
  output logic               out_program_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  codes_t           codes;
  result_t          res;
  result_t          out_r;
  logic             out_valid_r, out_valid_nxt;
  logic             in_valid_r, in_valid_nxt;
  logic [ByteW-1:0] in_byte_r;
  logic             out_free;
  logic             step;
  logic             in_take;

  assign cfg_ready = 1'b1;

  ufr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .codes    (codes)
  );

  ufr_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .codes   (codes),
    .res     (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_r.event_res;
  assign out_reply_byte     = out_r.reply_byte;
  assign out_payload_valid  = out_r.payload_valid;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_payload_offset = out_r.payload_offset;
  assign out_frame_length   = out_r.frame_length;
  assign out_flash_offset   = out_r.flash_offset;
  assign out_record_address = out_r.record_address;
  assign out_record_check   = out_r.record_check;
  assign out_frames_stored  = out_r.frames_stored;
  assign out_program_ready  = out_r.program_ready;

endmodule

// ===== sv/ufr_cfg_regs.sv =====
// Configuration registers holding the session and reply codes.
module ufr_cfg_regs
  import ufr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [ByteW-1:0]   wr_data,
  output codes_t             codes
);

  codes_t codes_r;
  codes_t codes_nxt;

  always_comb begin
    codes_nxt = codes_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_START_CODE: codes_nxt.start_code = wr_data;
        REG_END_CODE:   codes_nxt.end_code   = wr_data;
        REG_ACK_CODE:   codes_nxt.ack_code   = wr_data;
        REG_NACK_CODE:  codes_nxt.nack_code  = wr_data;
        default:        codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code <= START_CODE_RST;
      codes_r.end_code   <= END_CODE_RST;
      codes_r.ack_code   <= ACK_CODE_RST;
      codes_r.nack_code  <= NACK_CODE_RST;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  assign codes = codes_r;

endmodule

// ===== sv/ufr_frame_core.sv =====
// Frame parser state and per-byte result logic.
module ufr_frame_core
  import ufr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [ByteW-1:0] rx_byte,
  input  codes_t           codes,
  output result_t          res
);

  logic              at_boundary_r, at_boundary_nxt;
  logic [PosW-1:0]   byte_pos_r, byte_pos_nxt;
  logic [ByteW-1:0]  cur_len_r, cur_len_nxt;
  logic [ByteW-1:0]  frame_xor_r, frame_xor_nxt;
  logic [ByteW-1:0]  data_xor_r, data_xor_nxt;
  logic [AddrW-1:0]  tgt_off_r, tgt_off_nxt;
  logic              session_r, session_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [AddrW-1:0]  store_ptr_r, store_ptr_nxt;
  logic [PosW-1:0]   data_end;
  logic [PosW-1:0]   data_idx;

  assign data_end = HDR_LEN + {1'b0, cur_len_r};
  assign data_idx = byte_pos_r - HDR_LEN;

  always_comb begin
    at_boundary_nxt = at_boundary_r;
    byte_pos_nxt    = byte_pos_r;
    cur_len_nxt     = cur_len_r;
    frame_xor_nxt   = frame_xor_r;
    data_xor_nxt    = data_xor_r;
    tgt_off_nxt     = tgt_off_r;
    session_nxt     = session_r;
    count_nxt       = count_r;
    store_ptr_nxt   = store_ptr_r;
    res             = '0;

    priority if (at_boundary_r && rx_byte == codes.start_code) begin
      at_boundary_nxt   = 1'b0;
      byte_pos_nxt      = '0;
      session_nxt       = 1'b1;
      res.event_res     = EV_START;
      res.reply_byte    = codes.ack_code;
      res.frames_stored = count_r;
    end else if (at_boundary_r && rx_byte == codes.end_code) begin
      at_boundary_nxt   = 1'b1;
      byte_pos_nxt      = '0;
      session_nxt       = 1'b0;
      res.event_res     = EV_END;
      res.reply_byte    = codes.ack_code;
      res.frames_stored = count_r;
      res.program_ready = (count_r != '0);
      count_nxt         = '0;
      store_ptr_nxt     = '0;
    end else begin
      at_boundary_nxt = 1'b0;
      priority if (byte_pos_r == PosW'(0)) begin
        cur_len_nxt   = rx_byte;
        frame_xor_nxt = rx_byte;
        data_xor_nxt  = rx_byte;
        tgt_off_nxt   = '0;
        byte_pos_nxt  = PosW'(1);
      end else if (byte_pos_r == PosW'(1)) begin
        tgt_off_nxt   = {rx_byte, tgt_off_r[ByteW-1:0]};
        frame_xor_nxt = frame_xor_r ^ rx_byte;
        byte_pos_nxt  = PosW'(2);
      end else if (byte_pos_r == PosW'(2)) begin
        tgt_off_nxt   = {tgt_off_r[AddrW-1:ByteW], rx_byte};
        frame_xor_nxt = frame_xor_r ^ rx_byte;
        byte_pos_nxt  = HDR_LEN;
      end else if (byte_pos_r < data_end) begin
        frame_xor_nxt      = frame_xor_r ^ rx_byte;
        data_xor_nxt       = data_xor_r ^ rx_byte;
        res.payload_valid  = 1'b1;
        res.payload_byte   = rx_byte;
        res.payload_offset = data_idx[ByteW-1:0];
        byte_pos_nxt       = byte_pos_r + PosW'(1);
      end else begin
        at_boundary_nxt = 1'b1;
        byte_pos_nxt    = '0;
        priority if (!session_r) begin
          res.event_res = EV_DROP;
        end else if (frame_xor_r == rx_byte) begin
          res.event_res      = EV_ACCEPT;
          res.reply_byte     = codes.ack_code;
          res.record_address = store_ptr_r;
          res.record_check   = data_xor_r;
          store_ptr_nxt      = store_ptr_r + AddrW'(cur_len_r) + AddrW'(2);
          count_nxt          = count_r + CountW'(1);
        end else begin
          res.event_res  = EV_REJECT;
          res.reply_byte = codes.nack_code;
        end
      end
      res.frame_length  = cur_len_nxt;
      res.flash_offset  = tgt_off_nxt;
      res.frames_stored = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_boundary_r <= 1'b1;
      byte_pos_r    <= '0;
      cur_len_r     <= '0;
      frame_xor_r   <= '0;
      data_xor_r    <= '0;
      tgt_off_r     <= '0;
      session_r     <= 1'b0;
      count_r       <= '0;
      store_ptr_r   <= '0;
    end else if (step) begin
      at_boundary_r <= at_boundary_nxt;
      byte_pos_r    <= byte_pos_nxt;
      cur_len_r     <= cur_len_nxt;
      frame_xor_r   <= frame_xor_nxt;
      data_xor_r    <= data_xor_nxt;
      tgt_off_r     <= tgt_off_nxt;
      session_r     <= session_nxt;
      count_r       <= count_nxt;
      store_ptr_r   <= store_ptr_nxt;
    end
  end

endmodule

// ===== sv/ufr_checker.sv =====
// Port-level checks for the update frame receiver, bound to the top level.
module ufr_checker
  import ufr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [EventW-1:0] out_event_res,
  input logic              out_payload_valid,
  input logic [ByteW-1:0]  out_frame_length,
  input logic [AddrW-1:0]  out_flash_offset,
  input logic [AddrW-1:0]  out_record_address,
  input logic [ByteW-1:0]  out_record_check,
  input logic              out_program_ready
);

  a_hold_stalled_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_data_beat_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_event_res == EV_ABSORB)
    else $error("data beat carries a frame event");

  a_record_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_ACCEPT |->
      out_record_address == '0 && out_record_check == '0)
    else $error("record fields set without an accepted frame");

  a_ready_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_program_ready |-> out_event_res == EV_END)
    else $error("program ready outside an end code");

  a_session_codes_clear_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_START || out_event_res == EV_END) |->
      out_frame_length == '0 && out_flash_offset == '0)
    else $error("session code carries frame header fields");

endmodule

bind update_frame_receiver_unit ufr_checker u_ufr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_event_res      (out_event_res),
  .out_payload_valid  (out_payload_valid),
  .out_frame_length   (out_frame_length),
  .out_flash_offset   (out_flash_offset),
  .out_record_address (out_record_address),
  .out_record_check   (out_record_check),
  .out_program_ready  (out_program_ready)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the update frame receiver: random framed sessions, scoreboard.
module tb_top;
  import ufr_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int PHASE_BYTES = 330;

  class frame_tracker;
    codes_t      codes;
    bit          at_boundary;
    logic [PosW-1:0]   byte_pos;
    logic [ByteW-1:0]  frame_len;
    logic [ByteW-1:0]  frame_sum;
    logic [ByteW-1:0]  data_sum;
    logic [AddrW-1:0]  target_off;
    bit          session_open;
    logic [CountW-1:0] frame_count;
    logic [AddrW-1:0]  record_ptr;
    result_t     pending_results[$];
    int          failures;

    function new();
      codes.start_code = START_CODE_RST;
      codes.end_code   = END_CODE_RST;
      codes.ack_code   = ACK_CODE_RST;
      codes.nack_code  = NACK_CODE_RST;
      at_boundary  = 1'b1;
      byte_pos     = '0;
      frame_len    = '0;
      frame_sum    = '0;
      data_sum     = '0;
      target_off   = '0;
      session_open = 1'b0;
      frame_count  = '0;
      record_ptr   = '0;
      failures     = 0;
    endfunction

    function void set_code(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        REG_START_CODE: codes.start_code = val;
        REG_END_CODE:   codes.end_code   = val;
        REG_ACK_CODE:   codes.ack_code   = val;
        REG_NACK_CODE:  codes.nack_code  = val;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      result_t r;
      logic [PosW-1:0] pos;
      r = '0;
      r.event_res = EV_ABSORB;
      if (at_boundary && b == codes.start_code) begin
        at_boundary  = 1'b0;
        byte_pos     = '0;
        session_open = 1'b1;
        r.event_res  = EV_START;
        r.reply_byte = codes.ack_code;
        r.frames_stored = frame_count;
      end else if (at_boundary && b == codes.end_code) begin
        byte_pos     = '0;
        session_open = 1'b0;
        r.event_res  = EV_END;
        r.reply_byte = codes.ack_code;
        r.frames_stored = frame_count;
        r.program_ready = (frame_count != '0);
        frame_count  = '0;
        record_ptr   = '0;
      end else begin
        at_boundary = 1'b0;
        pos = byte_pos;
        if (pos == 0) begin
          frame_len  = b;
          frame_sum  = b;
          data_sum   = b;
          target_off = '0;
          byte_pos   = 1;
        end else if (pos == 1) begin
          target_off[15:8] = b;
          frame_sum ^= b;
          byte_pos   = 2;
        end else if (pos == 2) begin
          target_off[7:0] = b;
          frame_sum ^= b;
          byte_pos   = 3;
        end else if (pos < HDR_LEN + {1'b0, frame_len}) begin
          frame_sum ^= b;
          data_sum  ^= b;
          r.payload_valid  = 1'b1;
          r.payload_byte   = b;
          r.payload_offset = 8'(pos - HDR_LEN);
          byte_pos = pos + 1'b1;
        end else begin
          at_boundary = 1'b1;
          byte_pos    = '0;
          if (!session_open) begin
            r.event_res = EV_DROP;
          end else if (frame_sum == b) begin
            r.event_res      = EV_ACCEPT;
            r.reply_byte     = codes.ack_code;
            r.record_address = record_ptr;
            r.record_check   = data_sum;
            record_ptr  = record_ptr + AddrW'(frame_len) + 16'd2;
            frame_count = frame_count + 1'b1;
          end else begin
            r.event_res  = EV_REJECT;
            r.reply_byte = codes.nack_code;
          end
        end
        r.frame_length  = frame_len;
        r.flash_offset  = target_off;
        r.frames_stored = frame_count;
      end
      pending_results.push_back(r);
    endfunction

    function string describe(result_t r);
      return $sformatf("ev=%0d reply=%02h pv=%0d pb=%02h po=%0d len=%0d off=%04h addr=%04h chk=%02h n=%0d rdy=%0d",
                       r.event_res, r.reply_byte, r.payload_valid, r.payload_byte,
                       r.payload_offset, r.frame_length, r.flash_offset, r.record_address,
                       r.record_check, r.frames_stored, r.program_ready);
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $time, what);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        note_failure({"unexpected beat: ", describe(got)});
        return;
      end
      want = pending_results.pop_front();
      if (got !== want)
        note_failure({"expected ", describe(want), " got ", describe(got)});
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ByteW-1:0]   in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [EventW-1:0]  out_event_res;
  logic [ByteW-1:0]   out_reply_byte;
  logic               out_payload_valid;
  logic [ByteW-1:0]   out_payload_byte;
  logic [ByteW-1:0]   out_payload_offset;
  logic [ByteW-1:0]   out_frame_length;
  logic [AddrW-1:0]   out_flash_offset;
  logic [AddrW-1:0]   out_record_address;
  logic [ByteW-1:0]   out_record_check;
  logic [CountW-1:0]  out_frames_stored;
  logic               out_program_ready;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  result_t      seen_result;
  frame_tracker tracker = new();
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           sent_count = 0;
  int           cycle_count = 0;

  update_frame_receiver_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_reply_byte     (out_reply_byte),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_payload_offset (out_payload_offset),
    .out_frame_length   (out_frame_length),
    .out_flash_offset   (out_flash_offset),
    .out_record_address (out_record_address),
    .out_record_check   (out_record_check),
    .out_frames_stored  (out_frames_stored),
    .out_program_ready  (out_program_ready),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  assign seen_result = {out_event_res, out_reply_byte, out_payload_valid, out_payload_byte,
                        out_payload_offset, out_frame_length, out_flash_offset,
                        out_record_address, out_record_check, out_frames_stored,
                        out_program_ready};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(seen_result);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    sent_count++;
  endtask

  task automatic send_frame(input logic [ByteW-1:0] len, input logic [AddrW-1:0] off,
                            input bit corrupt);
    logic [ByteW-1:0] check;
    logic [ByteW-1:0] d;
    check = len ^ off[15:8] ^ off[7:0];
    send_byte(len);
    send_byte(off[15:8]);
    send_byte(off[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      d = ByteW'($urandom_range(0, 255));
      check ^= d;
      send_byte(d);
    end
    if (corrupt) check ^= ByteW'($urandom_range(1, 255));
    send_byte(check);
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_code(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_code(idx, val);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] pick_length(bit longest);
    if (longest) return 8'hFF;
    if ($urandom_range(0, 9) == 0) return ByteW'($urandom_range(13, 60));
    return ByteW'($urandom_range(0, 12));
  endfunction

  task automatic run_sessions(input int target, input bit long_first);
    int stop_at;
    int kind;
    int nframes;
    bit first;
    stop_at = sent_count + target;
    first   = long_first;
    while (sent_count < stop_at) begin
      while (!tracker.at_boundary) send_byte(ByteW'($urandom_range(0, 255)));
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        send_byte(tracker.codes.start_code);
        nframes = $urandom_range(1, 6);
        for (int f = 0; f < nframes; f++) begin
          if (f > 0 && $urandom_range(0, 9) == 0) send_byte(tracker.codes.start_code);
          send_frame(pick_length(first), AddrW'($urandom_range(0, 65535)),
                     $urandom_range(0, 99) < 15);
          first = 1'b0;
        end
        if ($urandom_range(0, 9) != 0) send_byte(tracker.codes.end_code);
      end else if (kind < 86) begin
        send_frame(pick_length(1'b0), AddrW'($urandom_range(0, 65535)),
                   $urandom_range(0, 99) < 15);
      end else if (kind < 92) begin
        send_byte(tracker.codes.end_code);
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom_range(0, 255)));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_START_CODE;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // end code and a frame with no session open
    send_byte(END_CODE_RST);
    send_frame(8'd0, 16'h1234, 1'b0);
    send_byte(START_CODE_RST);
    send_frame(8'd1, 16'hFF00, 1'b0);
    send_frame(8'd0, 16'h00FF, 1'b0);
    // restart inside the session, then a bad check byte
    send_byte(START_CODE_RST);
    send_frame(8'd2, 16'h8001, 1'b1);
    send_byte(END_CODE_RST);

    for (int p = 0; p < 5; p++) begin
      drain_results();
      case (p)
        1: begin
          write_code(REG_START_CODE, 8'h00);
          write_code(REG_END_CODE,   8'hFF);
          write_code(REG_ACK_CODE,   8'h00);
          write_code(REG_NACK_CODE,  8'hFF);
        end
        2: begin
          write_code(REG_START_CODE, 8'hFF);
          write_code(REG_END_CODE,   8'h00);
          write_code(REG_ACK_CODE,   8'hFF);
          write_code(REG_NACK_CODE,  8'h00);
        end
        3: begin
          write_code(REG_START_CODE, ByteW'($urandom_range(0, 255)));
          write_code(REG_END_CODE,   ByteW'($urandom_range(0, 255)));
          write_code(REG_ACK_CODE,   ByteW'($urandom_range(0, 255)));
          write_code(REG_NACK_CODE,  ByteW'($urandom_range(0, 255)));
        end
        4: begin
          write_code(REG_START_CODE, START_CODE_RST);
          write_code(REG_END_CODE,   END_CODE_RST);
          write_code(REG_ACK_CODE,   ACK_CODE_RST);
          write_code(REG_NACK_CODE,  NACK_CODE_RST);
        end
        default: ;
      endcase
      case (p % 4)
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        3: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_sessions(PHASE_BYTES, p == 1 || p == 3);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.pending_results.size() != 0) tracker.note_failure("results missing at end");
    if (tracker.failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ufr_pkg.sv
sv/ufr_cfg_regs.sv
sv/ufr_frame_core.sv
sv/update_frame_receiver_unit.sv
sv/ufr_checker.sv
tb/tb_top.sv
